// ----- design/gmf_pkg.sv -----
// ----------------------------------------------------------------------------
// gmf_pkg: shared definitions for the 3x3 min/max filter
// Widths, register map, codes, pipeline control struct and the compare
// function used by the window cells and the window combiner.
// ----------------------------------------------------------------------------
package gmf_pkg;

   localparam int LINE_WIDTH_MAX_DEF = 256;

   localparam int PIX_W      = 8;
   localparam int FW_W       = 9;
   localparam int FH_W       = 12;
   localparam int ROW_W      = FH_W + 1;
   localparam int COL_ROWS   = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic            MODE_MIN = 1'b0;
   localparam logic            MODE_MAX = 1'b1;
   localparam logic            TYPE_PIXEL = 1'b0;
   localparam logic            TYPE_FLUSH = 1'b1;

   localparam logic            MODE_RESET   = MODE_MIN;
   localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(176);
   localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(144);

   typedef logic [PIX_W-1:0] pixel_type;
   // Index 0 is the top row of a window column, index 2 the bottom row.
   typedef logic [COL_ROWS-1:0][PIX_W-1:0] column_type;

   typedef struct packed {
      logic have;
      logic last;
      logic top_en;
      logic bot_en;
      logic left_en;
      logic right_en;
   } win_ctrl_type;

   function automatic pixel_type pick_extreme(logic mode, pixel_type a, pixel_type b);
      pixel_type res;
      if (mode == MODE_MAX) begin
         res = (b > a) ? b : a;
      end else begin
         res = (b < a) ? b : a;
      end
      return res;
   endfunction

endpackage

// ----- design/gmf_ram.sv -----
// ----------------------------------------------------------------------------
// gmf_ram: generic RAM
// One write port and two read ports, read data registered. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module gmf_ram #(
   parameter int WIDTH = gmf_pkg::PIX_W,
   parameter int DEPTH = 2 * gmf_pkg::LINE_WIDTH_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/gmf_cell.sv -----
// ----------------------------------------------------------------------------
// gmf_cell: one window column cell
// Holds three pixels of a window column, passes them to the next cell on a
// shift and presents the extreme of the rows that lie inside the frame.
// ----------------------------------------------------------------------------
module gmf_cell (
   input  logic                  clock,
   input  logic                  shift,
   input  gmf_pkg::column_type   col_load,
   output gmf_pkg::column_type   col_held,
   input  logic                  mode,
   input  logic                  top_en,
   input  logic                  bot_en,
   output gmf_pkg::pixel_type    col_ext
);

   gmf_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_load;
      end
   end

   // The center row is always inside the frame.
   always_comb begin
      col_ext = col_ff[1];
      if (top_en) begin
         col_ext = gmf_pkg::pick_extreme(mode, col_ext, col_ff[0]);
      end
      if (bot_en) begin
         col_ext = gmf_pkg::pick_extreme(mode, col_ext, col_ff[2]);
      end
   end

   assign col_held = col_ff;

endmodule

// ----- design/gmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// gmf_ctrl: frame position tracker
// Keeps the row and column of the next item, decides how each item acts
// (pixel, flush or dropped) and which window places lie inside the frame,
// and forms the line store addresses.
// ----------------------------------------------------------------------------
module gmf_ctrl #(
   parameter int LINE_WIDTH_MAX = gmf_pkg::LINE_WIDTH_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  item_type,
   input  logic [gmf_pkg::FW_W-1:0]              frame_width,
   input  logic [gmf_pkg::FH_W-1:0]              frame_height,
   output logic                                  ignore,
   output logic                                  flush,
   output gmf_pkg::win_ctrl_type                 win,
   output logic [$clog2(LINE_WIDTH_MAX):0]       top_addr,
   output logic [$clog2(LINE_WIDTH_MAX):0]       mid_addr
);

   localparam int COL_W = $clog2(LINE_WIDTH_MAX);
   localparam int LIM_W = $clog2(LINE_WIDTH_MAX + 1);
   localparam int EW    = (gmf_pkg::FW_W > LIM_W) ? gmf_pkg::FW_W : LIM_W;
   localparam int RW    = gmf_pkg::ROW_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic [EW-1:0]    eff_w;
   logic [EW-1:0]    fw_ext;
   logic [EW-1:0]    c_next;
   logic [RW-1:0]    eff_h;
   logic [RW-1:0]    h_plus1;
   logic             wrap;
   logic [RW-1:0]    r;
   logic [COL_W-1:0] c;
   logic             start_res;
   logic             mid_res;

   always_comb begin
      fw_ext = EW'(frame_width);
      if (frame_width == '0) begin
         eff_w = EW'(1);
      end else if (fw_ext > EW'(LINE_WIDTH_MAX)) begin
         eff_w = EW'(LINE_WIDTH_MAX);
      end else begin
         eff_w = fw_ext;
      end
      eff_h   = (frame_height == '0) ? RW'(1) : RW'(frame_height);
      h_plus1 = eff_h + RW'(1);

      // A position left outside the frame by a register change restarts it.
      wrap = (row_ff > h_plus1) || (EW'(col_ff) >= eff_w);
      r    = wrap ? '0 : row_ff;
      c    = wrap ? '0 : col_ff;

      ignore = (item_type == gmf_pkg::TYPE_FLUSH) && (r < eff_h);
      flush  = (item_type == gmf_pkg::TYPE_FLUSH) || (r >= eff_h);

      // Start of a row finishes the last column of the row two above;
      // any other column finishes the previous column of the row above.
      start_res = (c == '0) && (r >= RW'(2));
      mid_res   = (c != '0) && (r >= RW'(1)) && (r <= eff_h);

      win.have     = start_res || mid_res;
      win.last     = start_res && (r == h_plus1);
      win.top_en   = start_res ? (r != RW'(2)) : (r != RW'(1));
      win.bot_en   = start_res ? (r <= eff_h) : (r < eff_h);
      win.left_en  = start_res ? (eff_w != EW'(1)) : (c != COL_W'(1));
      win.right_en = !start_res;

      c_next = EW'(c) + EW'(1);
      if (ignore) begin
         row_in = r;
         col_in = c;
      end else if (win.last) begin
         row_in = '0;
         col_in = '0;
      end else if (c_next >= eff_w) begin
         row_in = r + RW'(1);
         col_in = '0;
      end else begin
         row_in = r;
         col_in = c_next[COL_W-1:0];
      end

      top_addr = {r[0], c};
      mid_addr = {~r[0], c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

// ----- design/grayscale_3x3_min_max_filter_core.sv -----
// ----------------------------------------------------------------------------
// grayscale_3x3_min_max_filter_core: streaming 3x3 erosion / dilation
//
//   channel | direction | transfer carries
//   req_    | in        | tdata: pixel_in, tuser: req_type (0 pixel, 1 flush)
//   rsp_    | out       | tdata: pixel_out, tlast: frame_last
//   csr_    | in        | APB writes/reads of filter_mode, frame_width,
//           |           | frame_height at byte addresses 0, 4, 8
//
// One item is taken per cycle while the pipeline does not stall. A result
// leaves the output register after the item that completes its window has
// passed the line store read, the window cells and the output stage.
// Results lag the pixel stream by frame_width + 1 items; flush items drain.
// Reset loads the configuration registers with their defaults and clears
// the position and the valid flags; the line store needs no clear.
// A stalled result holds the output register; the two stages before it keep
// taking items until they are full.
// ----------------------------------------------------------------------------
module grayscale_3x3_min_max_filter_core #(
   parameter int LINE_WIDTH_MAX = gmf_pkg::LINE_WIDTH_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] pixel_in
   input  logic                              req_tuser,   // [0] req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] pixel_out
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gmf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gmf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gmf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int COL_W     = $clog2(LINE_WIDTH_MAX);
   localparam int ADDR_W    = COL_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int NCELL     = 3;

   // Configuration registers.
   logic                       mode_ff;
   logic [gmf_pkg::FW_W-1:0]   width_ff;
   logic [gmf_pkg::FH_W-1:0]   height_ff;
   logic [1:0]                 reg_index;
   logic                       csr_write;

   assign reg_index  = csr_paddr[gmf_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= gmf_pkg::MODE_RESET;
         width_ff  <= gmf_pkg::WIDTH_RESET;
         height_ff <= gmf_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            gmf_pkg::REG_MODE:   mode_ff   <= csr_pwdata[0];
            gmf_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[gmf_pkg::FW_W-1:0];
            gmf_pkg::REG_HEIGHT: height_ff <= csr_pwdata[gmf_pkg::FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         gmf_pkg::REG_MODE:   csr_prdata = gmf_pkg::CSR_DATA_W'(mode_ff);
         gmf_pkg::REG_WIDTH:  csr_prdata = gmf_pkg::CSR_DATA_W'(width_ff);
         gmf_pkg::REG_HEIGHT: csr_prdata = gmf_pkg::CSR_DATA_W'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Position tracking and item decode.
   logic                   accept;
   logic                   ignore;
   logic                   flush;
   gmf_pkg::win_ctrl_type  win;
   logic [ADDR_W-1:0]      top_addr;
   logic [ADDR_W-1:0]      mid_addr;

   assign accept = req_tvalid && req_tready;

   gmf_ctrl #(
      .LINE_WIDTH_MAX (LINE_WIDTH_MAX)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item_type    (req_tuser),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .ignore       (ignore),
      .flush        (flush),
      .win          (win),
      .top_addr     (top_addr),
      .mid_addr     (mid_addr)
   );

   // Line store: the bank of the row two above is read and then overwritten
   // with the incoming pixel at the same address.
   gmf_pkg::pixel_type rd_top;
   gmf_pkg::pixel_type rd_mid;

   gmf_ram #(
      .WIDTH (gmf_pkg::PIX_W),
      .DEPTH (RAM_DEPTH)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (accept && !ignore && !flush),
      .wr_addr   (top_addr),
      .wr_data   (req_tdata),
      .rd_en     (accept && !ignore),
      .rd_addr_a (top_addr),
      .rd_addr_b (mid_addr),
      .rd_data_a (rd_top),
      .rd_data_b (rd_mid)
   );

   // Pipeline: stage B waits for the read data, stage C is the window.
   logic                   vb_ff;
   gmf_pkg::win_ctrl_type  ctrl_b_ff;
   gmf_pkg::pixel_type     pix_b_ff;
   logic                   vc_ff;
   gmf_pkg::win_ctrl_type  ctrl_c_ff;
   logic                   out_valid_ff;
   gmf_pkg::pixel_type     out_pix_ff;
   logic                   out_last_ff;
   logic                   move_b;
   logic                   move_c;

   // An item without a result passes stage C even while the output stalls.
   assign move_c     = vc_ff && (!ctrl_c_ff.have || !out_valid_ff || rsp_tready);
   assign move_b     = vb_ff && (!vc_ff || move_c);
   assign req_tready = !vb_ff || move_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (accept && !ignore) begin
            vb_ff <= 1'b1;
         end else if (move_b) begin
            vb_ff <= 1'b0;
         end
         if (move_b) begin
            vc_ff <= 1'b1;
         end else if (move_c) begin
            vc_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !ignore) begin
         ctrl_b_ff <= win;
         pix_b_ff  <= flush ? '0 : req_tdata;
      end
      if (move_b) begin
         ctrl_c_ff <= ctrl_b_ff;
      end
   end

   // Chain of window column cells: cell 0 holds the newest column, cell 1
   // the center column and cell 2 the left column.
   gmf_pkg::column_type col_link [NCELL];
   gmf_pkg::pixel_type  col_ext  [NCELL];

   assign col_link[0] = {pix_b_ff, rd_mid, rd_top};

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      if (i < NCELL - 1) begin : g_link
         gmf_cell u_cell (
            .clock    (clock),
            .shift    (move_b),
            .col_load (col_link[i]),
            .col_held (col_link[i+1]),
            .mode     (mode_ff),
            .top_en   (ctrl_c_ff.top_en),
            .bot_en   (ctrl_c_ff.bot_en),
            .col_ext  (col_ext[i])
         );
      end else begin : g_end
         gmf_cell u_cell (
            .clock    (clock),
            .shift    (move_b),
            .col_load (col_link[i]),
            .col_held (),
            .mode     (mode_ff),
            .top_en   (ctrl_c_ff.top_en),
            .bot_en   (ctrl_c_ff.bot_en),
            .col_ext  (col_ext[i])
         );
      end
   end

   gmf_pkg::pixel_type result;

   always_comb begin
      result = col_ext[1];
      if (ctrl_c_ff.left_en) begin
         result = gmf_pkg::pick_extreme(mode_ff, result, col_ext[2]);
      end
      if (ctrl_c_ff.right_en) begin
         result = gmf_pkg::pick_extreme(mode_ff, result, col_ext[0]);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move_c && ctrl_c_ff.have) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move_c && ctrl_c_ff.have) begin
         out_pix_ff  <= result;
         out_last_ff <= ctrl_c_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for grayscale_3x3_min_max_filter_core
// Streams small grayscale frames through the filter under several register
// settings and random stalls on both channels. A scoreboard tracks the
// window state, predicts each min or max result and compares every result
// transfer against it.
// ----------------------------------------------------------------------------
module tb;
   import gmf_pkg::*;

   localparam int IDLE_MAX       = 12;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE         = 8;
   localparam int ITEM_TARGET    = 880;
   localparam int LINE_DEPTH     = LINE_WIDTH_MAX_DEF;

   class minmax_scoreboard;
      typedef struct {
         pixel_type pix;
         logic      last;
      } filtered_type;

      logic            mode;
      logic [FW_W-1:0] width_reg;
      logic [FH_W-1:0] height_reg;
      pixel_type       line_mem [2*LINE_DEPTH];
      pixel_type       win [9];
      int              col;
      int              row;
      filtered_type    expected_pixels [$];
      int              errors;

      function new();
         mode       = MODE_RESET;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (win[i]) win[i] = '0;
         col    = 0;
         row    = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_MODE:   mode = value[0];
            REG_WIDTH:  width_reg = value[FW_W-1:0];
            REG_HEIGHT: height_reg = value[FH_W-1:0];
            default: ;
         endcase
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return int'(width_reg);
      endfunction

      function int eff_height();
         return (height_reg == 0) ? 1 : int'(height_reg);
      endfunction

      // Extreme over the part of the window that lies inside the frame;
      // m is the window column that holds the center pixel.
      function pixel_type window_extreme(int m, int cr, int cc, int w, int h);
         int best;
         int v;
         best = (mode == MODE_MAX) ? 0 : 255;
         for (int r = 0; r < 3; r++) begin
            if (r == 0 && cr == 0) continue;
            if (r == 2 && cr + 1 >= h) continue;
            for (int c = m - 1; c <= m + 1 && c < 3; c++) begin
               if (c == m - 1 && cc == 0) continue;
               if (c == m + 1 && cc + 1 >= w) continue;
               v = win[r*3 + c];
               if ((mode == MODE_MAX) ? (v > best) : (v < best)) best = v;
            end
         end
         return pixel_type'(best);
      endfunction

      // Returns 1 when the item had an effect on the filter state.
      function bit note_item(logic kind, pixel_type pix);
         int        w;
         int        h;
         int        r;
         int        c;
         int        top_a;
         int        mid_a;
         bit        flush;
         bit        have;
         bit        last;
         pixel_type res;
         w = eff_width();
         h = eff_height();
         have = 1'b0;
         last = 1'b0;
         res = '0;
         if (row > h + 1 || col >= w) begin
            row = 0;
            col = 0;
         end
         if (kind == TYPE_FLUSH && row < h) return 1'b0;
         flush = (kind == TYPE_FLUSH) || (row >= h);
         r = row;
         c = col;
         // The first item of a row closes the last column of the row two above.
         if (c == 0 && r >= 2 && r - 2 < h) begin
            res  = window_extreme(2, r - 2, w - 1, w, h);
            have = 1'b1;
            last = (r - 2 == h - 1);
         end
         for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
         end
         top_a = (r % 2) * LINE_DEPTH + c;
         mid_a = ((r + 1) % 2) * LINE_DEPTH + c;
         win[2] = line_mem[top_a];
         win[5] = line_mem[mid_a];
         win[8] = flush ? pixel_type'(0) : pix;
         if (!flush) line_mem[top_a] = pix;
         if (c >= 1 && r >= 1 && r - 1 < h) begin
            res  = window_extreme(1, r - 1, c - 1, w, h);
            have = 1'b1;
            last = (r - 1 == h - 1) && (c == w);
         end
         if (last) begin
            row = 0;
            col = 0;
         end else begin
            col = c + 1;
            if (col >= w) begin
               col = 0;
               row = r + 1;
            end
         end
         if (have) expected_pixels.push_back('{pix: res, last: last});
         return 1'b1;
      endfunction

      function void check_result(pixel_type pix, logic last);
         filtered_type exp_r;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: expected no result, actual pixel_out %0d frame_last %0b",
                     $time, pix, last);
            return;
         end
         exp_r = expected_pixels.pop_front();
         if (pix !== exp_r.pix) begin
            errors++;
            $display("%0t: pixel_out expected %0d actual %0d", $time, exp_r.pix, pix);
         end
         if (last !== exp_r.last) begin
            errors++;
            $display("%0t: frame_last expected %0b actual %0b", $time, exp_r.last, last);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] pixel_in
   logic                  req_tuser;   // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] pixel_out
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   minmax_scoreboard sb;
   bit send_idles;
   bit take_idles;
   bit hold_request;
   int items_counted = 0;
   int quiet_cycles = 0;

   grayscale_3x3_min_max_filter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result checking and the watchdog on stalled transfers.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic int draw_gap(bit busy);
      return busy ? int'($urandom_range(0, IDLE_MAX)) : 0;
   endfunction

   function automatic pixel_type draw_pixel(int style);
      case (style)
         0: return pixel_type'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? pixel_type'(255) : pixel_type'(0);
         default: return ($urandom_range(0, 15) == 0) ? pixel_type'($urandom)
                                                       : pixel_type'(100);
      endcase
   endfunction

   // Result side: random back-pressure, plus one long hold when requested.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end
         hold = draw_gap(take_idles);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic csr_write(logic [1:0] idx, int unsigned value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic configure(logic m, int unsigned w, int unsigned h);
      csr_write(REG_MODE, m);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
   endtask

   task automatic send_item(logic kind, pixel_type pix);
      int gap;
      gap = draw_gap(send_idles);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = pix;
      do @(posedge clock); while (!req_tready);
      if (sb.note_item(kind, pix)) items_counted++;
      @(negedge clock);
   endtask

   // Pixels of a frame, with stray flush items mixed in; a broken frame
   // stops at a random point.
   task automatic send_frame(int w, int h, int style, bit broken);
      int total;
      int cut;
      total = w * h;
      cut = broken ? int'($urandom_range(0, total - 1)) : total;
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(0, 9) == 0) send_item(TYPE_FLUSH, pixel_type'($urandom));
         send_item(TYPE_PIXEL, draw_pixel(style));
      end
   endtask

   // Feed items until the frame's final result has been predicted. Past the
   // last row, pixel items serve as flush items too.
   task automatic finish_frame();
      do begin
         if (sb.row >= sb.eff_height() && $urandom_range(0, 1) != 0) begin
            send_item(TYPE_FLUSH, pixel_type'($urandom));
         end else begin
            send_item(TYPE_PIXEL, pixel_type'($urandom));
         end
      end while (!(sb.row == 0 && sb.col == 0));
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      pixel_type corner_pixels [9];
      int        base;
      int        phase;
      int        w;
      int        h;
      bit        broken;
      int        style;
      sb = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = TYPE_PIXEL;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      send_idles   = 1'b1;
      take_idles   = 1'b1;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // 3x3 frame with extreme values; a flush inside the frame is ignored,
      // and a pixel right after the frame acts as a flush.
      corner_pixels = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd1, 8'd254, 8'd128, 8'd64, 8'd32};
      configure(MODE_MIN, 3, 3);
      send_item(TYPE_FLUSH, 8'hA5);
      foreach (corner_pixels[i]) send_item(TYPE_PIXEL, corner_pixels[i]);
      send_item(TYPE_PIXEL, 8'hFF);
      finish_frame();
      wait_drained();

      // Zero width and height are taken as one.
      configure(MODE_MAX, 0, 0);
      send_item(TYPE_PIXEL, 8'd77);
      finish_frame();
      wait_drained();

      // Registers changed in the middle of a frame: first the mode, then a
      // height that puts the position past the flush range.
      configure(MODE_MAX, 2, 4095);
      repeat (6) send_item(TYPE_PIXEL, pixel_type'($urandom));
      wait_drained();
      csr_write(REG_MODE, MODE_MIN);
      repeat (2) send_item(TYPE_PIXEL, pixel_type'($urandom));
      wait_drained();
      csr_write(REG_HEIGHT, 1);
      finish_frame();
      wait_drained();

      base = items_counted;
      phase = 0;
      while (items_counted - base < ITEM_TARGET) begin
         if (phase == 2) begin
            w = 8;
            h = 6;
         end else if (phase == 4) begin
            // Full line store width, or a wider setting that is clipped to it.
            w = $urandom_range(LINE_DEPTH, 2 * LINE_DEPTH - 1);
            h = 1;
         end else begin
            case ($urandom_range(0, 15))
               0:       w = 0;
               1:       w = $urandom_range(1, 3);
               default: w = $urandom_range(1, 10);
            endcase
            case ($urandom_range(0, 9))
               0:       h = 0;
               1:       h = $urandom_range(1, 2);
               default: h = $urandom_range(1, 6);
            endcase
         end
         configure($urandom_range(0, 1) != 0 ? MODE_MAX : MODE_MIN, w, h);
         send_idles = ($urandom_range(0, 3) != 0);
         take_idles = ($urandom_range(0, 3) != 0);
         // Hold the result side off while the sender pushes without gaps,
         // so the pipeline fills and the input stalls.
         if (phase == 2 || $urandom_range(0, 9) == 0) begin
            hold_request = 1'b1;
            send_idles = 1'b0;
         end
         repeat ((phase == 4) ? 1 : $urandom_range(1, 3)) begin
            broken = (phase != 4 && $urandom_range(0, 7) == 0);
            style = $urandom_range(0, 2);
            send_frame(sb.eff_width(), sb.eff_height(), style, broken);
            if (broken) begin
               wait_drained();
               if ($urandom_range(0, 1) != 0) begin
                  csr_write(REG_MODE, (sb.mode == MODE_MAX) ? MODE_MIN : MODE_MAX);
               end else begin
                  csr_write(REG_HEIGHT, 1);
               end
            end
            finish_frame();
         end
         wait_drained();
         phase++;
      end

      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/gmf_pkg.sv
design/gmf_ram.sv
design/gmf_cell.sv
design/gmf_ctrl.sv
design/grayscale_3x3_min_max_filter_core.sv
bench/tb.sv
